// ===== sv/qye_pkg.sv =====
// Shared types and constants for the quaternion yaw extractor.
// No dependencies; every other file in this folder imports it.
package qye_pkg;

    // CORDIC datapath widths: x/y hold Q4.26 terms scaled by 2^24 plus gain growth,
    // z holds the angle in Q2.30 radians with room for the +/-pi base.
    localparam int XW = 60;
    localparam int ZW = 34;
    localparam int TABLE_DEPTH = 32;

    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [14:0] YAW_MAX = 15'sd12868;

    // atan(2^-i) in Q2.30
    localparam logic signed [ZW-1:0] ATAN_TABLE [0:TABLE_DEPTH-1] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F,
        34'sh00000003F, 34'sh00000001F, 34'sh00000000F, 34'sh000000008,
        34'sh000000004, 34'sh000000002, 34'sh000000001, 34'sh000000000
    };

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_quat_in;

    typedef struct packed {
        logic signed [14:0] yaw_angle;
        logic               degenerate;
    } t_yaw_out;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic valid;
        logic degen;
        logic zero;
    } t_ctl;

endpackage

// ===== sv/qye_front.sv =====
// Front end: component products, atan2 terms, norm test and CORDIC pre-rotation.
// Three register stages. Depends on qye_pkg.
module qye_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  qye_pkg::t_quat_in i_quat,
    input  logic [31:0]       i_min_norm,
    output qye_pkg::t_vec     o_vec,
    output qye_pkg::t_ctl     o_ctl
);
    import qye_pkg::*;

    // stage A: products
    logic               r_va;
    logic        [30:0] r_pww, r_pxx, r_pyy, r_pzz;
    logic signed [31:0] r_pwz, r_pxy;
    logic signed [31:0] n_pww, n_pxx, n_pyy, n_pzz;

    assign n_pww = i_quat.quat_w * i_quat.quat_w;
    assign n_pxx = i_quat.quat_x * i_quat.quat_x;
    assign n_pyy = i_quat.quat_y * i_quat.quat_y;
    assign n_pzz = i_quat.quat_z * i_quat.quat_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_pww <= n_pww[30:0];
        r_pxx <= n_pxx[30:0];
        r_pyy <= n_pyy[30:0];
        r_pzz <= n_pzz[30:0];
        r_pwz <= i_quat.quat_w * i_quat.quat_z;
        r_pxy <= i_quat.quat_x * i_quat.quat_y;
    end

    // stage B: norm^2 (Q4.26), sine term s and cosine term c
    logic               r_vb;
    logic        [32:0] r_norm2;
    logic signed [33:0] r_s;
    logic signed [32:0] r_c;
    logic        [32:0] n_norm2;
    logic        [32:0] n_ssum;
    logic        [32:0] n_c;

    assign n_norm2 = {2'b00, r_pww} + {2'b00, r_pxx} + {2'b00, r_pyy} + {2'b00, r_pzz};
    assign n_ssum  = {r_pwz[31], r_pwz} + {r_pxy[31], r_pxy};
    assign n_c     = {2'b00, r_pww} + {2'b00, r_pxx} - {2'b00, r_pyy} - {2'b00, r_pzz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_norm2 <= n_norm2;
        r_s     <= $signed({n_ssum, 1'b0});
        r_c     <= $signed(n_c);
    end

    // stage C: threshold test and quadrant fold into the right half plane
    logic signed [XW-1:0] n_x0, n_y0;
    t_vec                 n_vec;
    t_vec                 r_vec;
    t_ctl                 r_ctl;

    assign n_x0 = {{(XW-57){r_c[32]}}, r_c, 24'b0};
    assign n_y0 = {{(XW-58){r_s[33]}}, r_s, 24'b0};

    always_comb begin
        if (r_c[32]) begin
            n_vec.x = -n_x0;
            n_vec.y = -n_y0;
            n_vec.z = r_s[33] ? -PI_Q30 : PI_Q30;
        end else begin
            n_vec.x = n_x0;
            n_vec.y = n_y0;
            n_vec.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= r_vb;
            r_ctl.degen <= (r_norm2 <= {1'b0, i_min_norm});
            r_ctl.zero  <= (r_s == '0) && (r_c == '0);
        end
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;
    assign o_ctl = r_ctl;

endmodule

// ===== sv/qye_cell.sv =====
// One CORDIC vectoring micro-rotation with its own register stage.
// Depends on qye_pkg (angle table, datapath types).
module qye_cell #(
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qye_pkg::t_vec i_vec,
    input  qye_pkg::t_ctl i_ctl,
    output qye_pkg::t_vec o_vec,
    output qye_pkg::t_ctl o_ctl
);
    import qye_pkg::*;

    logic signed [XW-1:0] n_xs, n_ys;
    t_vec                 n_vec;
    t_vec                 r_vec;
    t_ctl                 r_ctl;

    // arithmetic shifts floor, matching the bit-exact definition
    assign n_xs = i_vec.x >>> SHIFT;
    assign n_ys = i_vec.y >>> SHIFT;

    always_comb begin
        if (!i_vec.y[XW-1]) begin
            n_vec.x = i_vec.x + n_ys;
            n_vec.y = i_vec.y - n_xs;
            n_vec.z = i_vec.z + ATAN_TABLE[SHIFT];
        end else begin
            n_vec.x = i_vec.x - n_ys;
            n_vec.y = i_vec.y + n_xs;
            n_vec.z = i_vec.z - ATAN_TABLE[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;
    assign o_ctl = r_ctl;

endmodule

// ===== sv/qye_out.sv =====
// Output stage: rounds the Q2.30 angle to Q3.12, clamps to +/-pi, applies flags.
// Depends on qye_pkg.
module qye_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qye_pkg::t_vec     i_vec,
    input  qye_pkg::t_ctl     i_ctl,
    output qye_pkg::t_yaw_out o_result,
    output logic              o_done
);
    import qye_pkg::*;

    logic signed [ZW:0]   n_sum;
    logic signed [ZW-18:0] n_rnd;
    logic signed [14:0]   n_yaw;
    t_yaw_out             r_result;
    logic                 r_done;

    assign n_sum = {i_vec.z[ZW-1], i_vec.z} + (ZW+1)'(1 << 17);
    assign n_rnd = n_sum[ZW:18];

    always_comb begin
        if (i_ctl.degen || i_ctl.zero) begin
            n_yaw = '0;
        end else if (n_rnd > (ZW-17)'(YAW_MAX)) begin
            n_yaw = YAW_MAX;
        end else if (n_rnd < -(ZW-17)'(YAW_MAX)) begin
            n_yaw = -YAW_MAX;
        end else begin
            n_yaw = n_rnd[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
        r_result.yaw_angle  <= n_yaw;
        r_result.degenerate <= i_ctl.degen;
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

// ===== sv/quaternion_yaw_extract.sv =====
// Quaternion yaw extractor: top level with the config register and the cell chain.
// Depends on qye_pkg, qye_front, qye_cell, qye_out.
//
// Takes one quaternion (Q2.13 components) per clock and returns its yaw in Q3.12
// radians, atan2(2(wz+xy), w^2+x^2-y^2-z^2), from a chain of CORDIC_ITERATIONS
// rotation cells. busy never rises, so a word can be started on every cycle;
// each result appears CORDIC_ITERATIONS+4 cycles after its start (three front
// stages, one per cell, one output stage) and stays on o_result for one cycle
// only, flagged by o_done, so the receiver must take it then. Quaternions whose
// squared norm (Q4.26) is at or below min_norm_squared give yaw 0 with the
// degenerate bit set; write the threshold only while no word is in flight.
module quaternion_yaw_extract #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qye_pkg::t_quat_in i_quat,
    output qye_pkg::t_yaw_out o_result,
    output logic              o_done,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import qye_pkg::*;

    logic [31:0] r_min_norm;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = r_min_norm;

    // single register; every address in the decoded range maps to it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_norm <= '0;
        end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00 || 1'b1)) begin
            r_min_norm <= pwdata;
        end
    end

    t_vec w_vec [0:CORDIC_ITERATIONS];
    t_ctl w_ctl [0:CORDIC_ITERATIONS];

    qye_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_quat     (i_quat),
        .i_min_norm (r_min_norm),
        .o_vec      (w_vec[0]),
        .o_ctl      (w_ctl[0])
    );

    for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
        qye_cell #(
            .SHIFT (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vec   (w_vec[g]),
            .i_ctl   (w_ctl[g]),
            .o_vec   (w_vec[g+1]),
            .o_ctl   (w_ctl[g+1])
        );
    end

    qye_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vec    (w_vec[CORDIC_ITERATIONS]),
        .i_ctl    (w_ctl[CORDIC_ITERATIONS]),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule
